>>> hw/rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  // Frame layout: key id, message id, then a 32-bit payload length
  localparam int unsigned MAX_FRAME_BYTES = 8192;
  localparam int unsigned HDR_BYTES       = 20;
  localparam int unsigned KEY_END         = 8;
  localparam int unsigned MSG_END         = 16;

  localparam int unsigned HDR_CNT_W = 5;

  // Reset value of the payload limit register
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'(MAX_FRAME_BYTES - HDR_BYTES);

  // One result request as it leaves the deframer
  typedef struct packed {
    logic [63:0] key_id;
    logic [63:0] msg_id;
    logic [31:0] payload_len;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last;
    logic        length_error;
  } lppd_result_t;

endpackage

>>> hw/rtl/lppd_if.sv
// ----------------------------------------------------------------------------
// lppd byte and packet channels
// Valid/ready channels for the received byte stream and the deframed results.
// ----------------------------------------------------------------------------
interface lppd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lppd_pkt_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_id;
  logic [63:0] msg_id;
  logic [31:0] payload_len;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        last;
  logic        length_error;

  modport source (output valid, output key_id, output msg_id, output payload_len,
                  output payload_byte, output byte_valid, output last,
                  output length_error, input ready);
  modport sink   (input valid, input key_id, input msg_id, input payload_len,
                  input payload_byte, input byte_valid, input last,
                  input length_error, output ready);
endinterface

>>> hw/rtl/lppd_out_buf.sv
// ----------------------------------------------------------------------------
// lppd_out_buf
// Two-entry result buffer: decouples the parser from output back-pressure.
// ----------------------------------------------------------------------------
module lppd_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lppd_pkg::lppd_result_t push_data_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output lppd_pkg::lppd_result_t data_o
);
  import lppd_pkg::*;

  lppd_result_t mem_q [2];
  logic         wptr_q, wptr_d;
  logic         rptr_q, rptr_d;
  logic [1:0]   count_q, count_d;
  logic         do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and fill level
  always_comb begin
    wptr_d  = push_i ? ~wptr_q : wptr_q;
    rptr_d  = do_pop ? ~rptr_q : rptr_q;
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Gathers a 20-byte big-endian header (key id, message id, length) and
// streams the payload bytes that follow, tagged with the header fields.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   in_byte
// out_o     out  valid/ready   key_id, msg_id, payload_len, payload_byte,
//                              byte_valid, last, length_error
// cfg       in   cfg_we_i      cfg_wdata_i (max_payload)
//
// One byte is accepted per cycle while the output buffer has space; a result
// is ready in the buffer the cycle after its byte is taken. The 2-entry output
// buffer sets the figure: input ready drops only while both entries are full.
// Reset clears the parser to expect a header and sets max_payload to 8172.
// A stalled output holds its request; the parser stops when the buffer fills.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
  input  logic              clk_i,
  input  logic              rst_ni,
  lppd_byte_if.sink         in_i,
  lppd_pkt_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import lppd_pkg::*;

  logic [15:0]          max_pay_q;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [63:0]          key_q, key_d;
  logic [63:0]          msg_q, msg_d;
  logic [31:0]          len_q, len_d;
  logic [31:0]          left_q, left_d;
  logic                 in_pay_q, in_pay_d;

  logic                 accept;
  logic                 res_push;
  lppd_result_t         res;
  logic                 buf_space;
  logic                 buf_valid;
  lppd_result_t         buf_data;

  assign in_i.ready = buf_space;
  assign accept     = in_i.valid && buf_space;

  // Hold the payload limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pay_q <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      max_pay_q <= cfg_wdata_i;
    end
  end

  // Parse one byte: shift header in, or count down the payload
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    key_d     = key_q;
    msg_d     = msg_q;
    len_d     = len_q;
    left_d    = left_q;
    in_pay_d  = in_pay_q;
    res_push  = 1'b0;
    res       = '0;
    if (accept) begin
      if (in_pay_q) begin
        left_d           = left_q - 32'd1;
        res_push         = 1'b1;
        res.payload_byte = in_i.in_byte;
        res.byte_valid   = 1'b1;
        res.last         = (left_q == 32'd1);
        if (left_q == 32'd1) begin
          in_pay_d  = 1'b0;
          hdr_cnt_d = '0;
        end
      end else begin
        if (hdr_cnt_q < HDR_CNT_W'(KEY_END)) begin
          key_d = {key_q[55:0], in_i.in_byte};
        end else if (hdr_cnt_q < HDR_CNT_W'(MSG_END)) begin
          msg_d = {msg_q[55:0], in_i.in_byte};
        end else begin
          len_d = {len_q[23:0], in_i.in_byte};
        end
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
        // Last header byte: flag oversize, report empty, or enter payload
        if (hdr_cnt_q == HDR_CNT_W'(HDR_BYTES - 1)) begin
          hdr_cnt_d = '0;
          if (len_d > {16'd0, max_pay_q}) begin
            res_push         = 1'b1;
            res.last         = 1'b1;
            res.length_error = 1'b1;
          end else if (len_d == 32'd0) begin
            res_push = 1'b1;
            res.last = 1'b1;
          end else begin
            left_d   = len_d;
            in_pay_d = 1'b1;
          end
        end
      end
    end
    res.key_id      = key_d;
    res.msg_id      = msg_d;
    res.payload_len = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      key_q     <= '0;
      msg_q     <= '0;
      len_q     <= '0;
      left_q    <= '0;
      in_pay_q  <= 1'b0;
    end else begin
      hdr_cnt_q <= hdr_cnt_d;
      key_q     <= key_d;
      msg_q     <= msg_d;
      len_q     <= len_d;
      left_q    <= left_d;
      in_pay_q  <= in_pay_d;
    end
  end

  // Buffer results toward the output channel
  lppd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .space_o     (buf_space),
    .valid_o     (buf_valid),
    .pop_i       (out_o.ready),
    .data_o      (buf_data)
  );

  assign out_o.valid        = buf_valid;
  assign out_o.key_id       = buf_data.key_id;
  assign out_o.msg_id       = buf_data.msg_id;
  assign out_o.payload_len  = buf_data.payload_len;
  assign out_o.payload_byte = buf_data.payload_byte;
  assign out_o.byte_valid   = buf_data.byte_valid;
  assign out_o.last         = buf_data.last;
  assign out_o.length_error = buf_data.length_error;

endmodule

>>> tb/sv/length_prefixed_packet_deframer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_test
// Drives byte streams into the deframer and checks every result request
// against a cycle-free model of the header parser and payload counter.
// Directed frames cover empty, oversized and boundary lengths and the extreme
// limit settings. Random frames, cut-off headers and stray bytes then run
// under several limits. Both channels pause at random between requests.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_test;
  import lppd_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_e;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  lppd_byte_if byte_ch ();
  lppd_pkt_if  pkt_ch ();

  length_prefixed_packet_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (byte_ch),
    .out_o       (pkt_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model of the parser
  int unsigned  hdr_cnt;
  logic [63:0]  key_acc;
  logic [63:0]  msg_acc;
  logic [31:0]  len_acc;
  logic [31:0]  bytes_remaining;
  bit           in_body;
  logic [15:0]  limit_reg;
  lppd_result_t deframed_q[$];

  idle_mode_e   src_mode;
  idle_mode_e   snk_mode;
  bit           src_busy;
  int           byte_cnt;
  int           result_cnt;
  int           err_cnt;
  int           quiet_cycles;
  lppd_result_t want;

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_HEAVY: return $urandom_range(0, 16);
      default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                result_cnt, name, got, want_v));
  endtask

  // Append one predicted result request
  task automatic queue_result(input lppd_result_t r);
    deframed_q.insert(deframed_q.size(), r);
  endtask

  // Advance the model by one accepted byte, queue any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    lppd_result_t r;
    r = '{key_id: key_acc, msg_id: msg_acc, payload_len: len_acc, payload_byte: 8'h00,
          byte_valid: 1'b0, last: 1'b1, length_error: 1'b0};
    if (in_body) begin
      bytes_remaining = bytes_remaining - 32'd1;
      r.payload_byte = b;
      r.byte_valid   = 1'b1;
      r.last         = (bytes_remaining == 32'd0);
      queue_result(r);
      if (r.last) begin
        in_body = 1'b0;
        hdr_cnt = 0;
      end
      return;
    end
    // Shift header bytes in, most significant first
    if (hdr_cnt < KEY_END) key_acc = {key_acc[55:0], b};
    else if (hdr_cnt < MSG_END) msg_acc = {msg_acc[55:0], b};
    else len_acc = {len_acc[23:0], b};
    hdr_cnt++;
    if (hdr_cnt < HDR_BYTES) return;
    hdr_cnt = 0;
    r.key_id      = key_acc;
    r.msg_id      = msg_acc;
    r.payload_len = len_acc;
    if (len_acc > {16'h0000, limit_reg}) begin
      r.length_error = 1'b1;
      queue_result(r);
    end else if (len_acc == 32'd0) begin
      queue_result(r);
    end else begin
      bytes_remaining = len_acc;
      in_body         = 1'b1;
    end
  endtask

  // Offer one byte after a random pause, hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait(src_mode);
    if (gap > 0) begin
      if (src_busy) byte_ch.valid <= 1'b0;
      src_busy = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    src_busy = 1'b1;
    do @(posedge clk_i); while (byte_ch.ready !== 1'b1);
    deframe_byte(b);
    byte_cnt++;
  endtask

  task automatic stop_source();
    if (src_busy) byte_ch.valid <= 1'b0;
    src_busy = 1'b0;
  endtask

  // Pad with zeros until the parser expects a fresh header
  task automatic realign();
    while (in_body || hdr_cnt != 0) send_byte(8'h00);
  endtask

  task automatic drain();
    stop_source();
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    realign();
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    limit_reg = value;
  endtask

  // Header plus payload; fill below zero means random payload bytes
  task automatic send_frame(input logic [63:0] key, input logic [63:0] msg,
                            input logic [31:0] len, input int fill);
    int unsigned body;
    for (int i = 0; i < 8; i++) send_byte(key[63-8*i -: 8]);
    for (int i = 0; i < 8; i++) send_byte(msg[63-8*i -: 8]);
    for (int i = 0; i < 4; i++) send_byte(len[31-8*i -: 8]);
    body = (len > {16'h0000, limit_reg}) ? 0 : len;
    for (int unsigned i = 0; i < body; i++)
      send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0]);
  endtask

  // Mostly short payloads, with empty, boundary and oversized lengths mixed in
  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 30)
      return ($urandom_range(0, 1) == 1) ? {16'h0000, limit_reg} + 32'd1
                                         : ($urandom | 32'h0001_0000);
    if (limit_reg == 16'd0) return 32'd0;
    if (r < 40 && limit_reg <= 16'd64) return {16'h0000, limit_reg};
    return $urandom_range(1, (limit_reg < 16'd16) ? limit_reg : 16);
  endfunction

  task automatic test_reset_limit();
    send_frame(64'd1, 64'd2, {16'h0000, MAX_PAYLOAD_RST} + 32'd1, -1);
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF, -1);
  endtask

  task automatic test_header_fields();
    send_frame(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'd0, -1);
    send_frame(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 8'hFF);
    send_frame(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd2, 8'h00);
  endtask

  task automatic test_limit_extremes();
    write_limit(16'h0000);
    send_frame(64'h5A, 64'hA5, 32'd0, -1);
    send_frame(64'h5A, 64'hA5, 32'd1, -1);
    write_limit(16'hFFFF);
    send_frame(64'h1, 64'h1, 32'h0001_0000, -1);
    send_frame(64'h2, 64'h2, 32'd3, -1);
    write_limit(16'd5);
    send_frame(64'h3, 64'h3, 32'd5, -1);
    send_frame(64'h4, 64'h4, 32'd6, -1);
  endtask

  task automatic test_random_traffic(input logic [15:0] limit, input idle_mode_e s_mode,
                                     input idle_mode_e k_mode, input int n_bytes);
    int start;
    int pick;
    write_limit(limit);
    src_mode = s_mode;
    snk_mode = k_mode;
    start    = byte_cnt;
    while (byte_cnt - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_frame({$urandom, $urandom}, {$urandom, $urandom}, pick_length(), -1);
      end else begin
        // Cut-off header or stray bytes, then resync on a header boundary
        repeat ($urandom_range(1, (pick < 90) ? 19 : 40))
          send_byte(8'($urandom_range(0, 255)));
        realign();
      end
    end
  endtask

  // Hold or release the result channel, one random pause per request
  initial begin
    int stall;
    pkt_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(snk_mode);
      if (stall > 0) begin
        pkt_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pkt_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1)) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1) begin
      if (deframed_q.size() == 0) begin
        report_mismatch($sformatf("result %0d: none expected", result_cnt));
      end else begin
        want = deframed_q.pop_front();
        check_field("key_id",       pkt_ch.key_id,       want.key_id);
        check_field("msg_id",       pkt_ch.msg_id,       want.msg_id);
        check_field("payload_len",  pkt_ch.payload_len,  want.payload_len);
        check_field("payload_byte", pkt_ch.payload_byte, want.payload_byte);
        check_field("byte_valid",   pkt_ch.byte_valid,   want.byte_valid);
        check_field("last",         pkt_ch.last,         want.last);
        check_field("length_error", pkt_ch.length_error, want.length_error);
      end
      result_cnt++;
    end
  end

  // Drop the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
        (pkt_ch.valid === 1'b1 && pkt_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("length_prefixed_packet_deframer_test: done, errors");
      $finish;
    end
  end

  initial begin
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 16'h0000;
    rst_ni          <= 1'b0;
    hdr_cnt         = 0;
    key_acc         = '0;
    msg_acc         = '0;
    len_acc         = '0;
    bytes_remaining = '0;
    in_body         = 1'b0;
    limit_reg       = MAX_PAYLOAD_RST;
    src_mode        = IDLE_SOME;
    snk_mode        = IDLE_SOME;
    src_busy        = 1'b0;
    byte_cnt        = 0;
    result_cnt      = 0;
    err_cnt         = 0;
    quiet_cycles    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limit();
    test_header_fields();
    test_limit_extremes();
    test_random_traffic(16'd16, IDLE_HEAVY, IDLE_HEAVY, 200);
    test_random_traffic(16'd0, IDLE_SOME, IDLE_HEAVY, 200);
    test_random_traffic(16'hFFFF, IDLE_NONE, IDLE_NONE, 200);
    test_random_traffic(16'($urandom_range(1, 64)), IDLE_HEAVY, IDLE_SOME, 200);
    test_random_traffic(MAX_PAYLOAD_RST, IDLE_SOME, IDLE_SOME, 200);

    drain();
    if (err_cnt == 0) begin
      $display("length_prefixed_packet_deframer_test: done, clean");
    end else begin
      $display("length_prefixed_packet_deframer_test: done, errors");
    end
    $finish;
  end

endmodule

>>> length_prefixed_packet_deframer.f
hw/rtl/lppd_pkg.sv
hw/rtl/lppd_if.sv
hw/rtl/lppd_out_buf.sv
hw/rtl/length_prefixed_packet_deframer.sv
tb/sv/length_prefixed_packet_deframer_test.sv
